// ----- hdl/hidkev_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hidkev_pkg
// Shared types, constants and helpers of the HID report to key event block.
// ----------------------------------------------------------------------------
package hidkev_pkg;

	// sizing
	localparam int HID_PORTS = 2;
	localparam int MAP_PAGES = 5;
	localparam int MAP_SLOTS = MAP_PAGES * 32;
	localparam int PAGE_W    = $clog2(MAP_PAGES);
	localparam int SLOT_W    = $clog2(MAP_SLOTS);
	localparam int MOD_PAGE  = 4;
	localparam int KEY_BYTES = 6;
	localparam int PAD_KEYS  = 5;

	localparam logic [7:0] RELEASE_BIT = 8'h80;

	// gamepad bits watched, in event order
	localparam logic [3:0] PAD_BITS [PAD_KEYS] = '{4'd6, 4'd7, 4'd13, 4'd11, 4'd9};

	typedef enum logic [1:0] {
		EV_MOUSE_X = 2'd0,
		EV_MOUSE_Y = 2'd1,
		EV_KEY     = 2'd2,
		EV_RESET   = 2'd3
	} event_kind_t;

	typedef enum logic [1:0] {
		RPT_KEYBOARD = 2'd0,
		RPT_MOUSE    = 2'd1,
		RPT_GAMEPAD  = 2'd2,
		RPT_OTHER    = 2'd3
	} report_kind_t;

	typedef enum logic {
		OP_REPORT    = 1'b0,
		OP_MAP_WRITE = 1'b1
	} operation_t;

	typedef enum logic [2:0] {
		CFG_PASSTHRU    = 3'd0,
		CFG_RESET_COMBO = 3'd1,
		CFG_PAD_BIT6    = 3'd2,
		CFG_PAD_BIT7    = 3'd3,
		CFG_PAD_BIT13   = 3'd4,
		CFG_PAD_BIT11   = 3'd5,
		CFG_PAD_BIT9    = 3'd6
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KB_READ,
		ST_KB_DIFF,
		ST_KB_SCAN,
		ST_MOUSE_X,
		ST_MOUSE_Y,
		ST_PAD,
		ST_FINISH
	} state_t;

	// pressed map page memory access
	typedef struct packed {
		logic              re;
		logic              we;
		logic [PAGE_W-1:0] addr;
		logic [31:0]       wdata;
	} page_req_t;

	// translation memory access
	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [6:0]        wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} xlat_req_t;

	// pressed bits of one map page as given by a keyboard report
	function automatic logic [31:0] fresh_page(input logic [63:0] bytes,
			input logic [PAGE_W-1:0] page);
		logic [31:0] bits;
		logic [7:0]  key;
		bits = '0;
		key  = '0;
		if (page == PAGE_W'(MOD_PAGE)) begin
			bits[7:0] = bytes[63:56];
		end
		for (int i = 0; i < KEY_BYTES; i++) begin
			key = bytes[8*(KEY_BYTES-1-i) +: 8];
			if (key != 8'd0 && !key[7] && PAGE_W'(key[6:5]) == page) begin
				bits[key[4:0]] = 1'b1;
			end
		end
		return bits;
	endfunction

	// index of the lowest set bit
	function automatic logic [4:0] lowest_bit(input logic [31:0] vec);
		logic [4:0] idx;
		idx = '0;
		for (int i = 31; i >= 0; i--) begin
			if (vec[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/hidkev_xlat_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hidkev_xlat_ram
// Key translation memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hidkev_xlat_ram (
	input  wire logic                  clk,
	input  wire hidkev_pkg::xlat_req_t req,
	output logic [6:0]                 rd_data
);

	logic [6:0] mem [hidkev_pkg::MAP_SLOTS];
	logic [6:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ----- hdl/hidkev_page_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hidkev_page_ram
// Pressed map memory, one 32-bit page per entry; pages never written read
// as zero through a valid bit per page.
// ----------------------------------------------------------------------------
module hidkev_page_ram (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hidkev_pkg::page_req_t req,
	output logic [31:0]                rd_data
);

	logic [31:0]                      mem [hidkev_pkg::MAP_PAGES];
	logic [hidkev_pkg::MAP_PAGES-1:0] vld_q;
	logic [31:0]                      rd_data_q;
	logic                             rd_vld_q;

	// storage and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.addr];
		end
	end

	// page valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				rd_vld_q <= vld_q[req.addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : 32'd0;

endmodule
`default_nettype wire

// ----- hdl/hid_report_to_key_events.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hid_report_to_key_events
// Converts HID keyboard, mouse and gamepad reports into raw key events.
// ----------------------------------------------------------------------------
// One item is worked on at a time; report_stall is high from the cycle after
// acceptance until its last event has moved to the output register. A map
// write is taken at acceptance; a mouse report steps through its X and Y
// states, a gamepad report through its watched buttons. A keyboard report
// walks the pressed map page by page (read, compare and write back, then
// scan), with one translation memory read for each changed slot.
// Downstream stall can hold any item.
// Every key map slot must be written before a report can change it.
// ----------------------------------------------------------------------------
module hid_report_to_key_events (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// report channel
	input  wire logic        report_valid,
	output logic             report_stall,
	input  wire logic        operation,
	input  wire logic        port,
	input  wire logic [1:0]  report_kind,
	input  wire logic [63:0] report_bytes,
	input  wire logic [13:0] pad_buttons,
	input  wire logic [7:0]  map_index,
	input  wire logic [6:0]  map_value,
	// event channel
	output logic             event_valid,
	input  wire logic        event_stall,
	output logic [1:0]       event_kind,
	output logic [7:0]       button_state,
	output logic [7:0]       event_code,
	output logic             last,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	localparam int PAGE_W = hidkev_pkg::PAGE_W;
	localparam int SLOT_W = hidkev_pkg::SLOT_W;

	hidkev_pkg::state_t state_q, state_d;

	// configuration registers
	logic       passthru_q;
	logic [7:0] combo_q;
	logic [6:0] pad_code_q [hidkev_pkg::PAD_KEYS];

	// report state
	logic [7:0]  mouse_button_q;
	logic [13:0] pad_prev_q [hidkev_pkg::HID_PORTS];

	// item working registers
	logic [63:0]       report_q;
	logic [PAGE_W-1:0] page_q;
	logic [31:0]       diff_q;
	logic [31:0]       fresh_q;
	logic              s1_valid_q;
	logic              rel_s1;
	logic [4:0]        pad_now_q;
	logic [4:0]        pad_diff_q;
	logic [2:0]        pad_step_q;

	// pending event and output register
	logic                    pend_valid_q;
	hidkev_pkg::event_kind_t pend_kind_q;
	logic [7:0]              pend_code_q;
	logic                    out_valid_q;
	hidkev_pkg::event_kind_t out_kind_q;
	logic [7:0]              out_button_q;
	logic [7:0]              out_code_q;
	logic                    out_last_q;

	// memories
	hidkev_pkg::page_req_t page_req;
	hidkev_pkg::xlat_req_t xlat_req;
	logic [31:0]           page_rd;
	logic [6:0]            xlat_rd;

	// control
	logic                    accept;
	logic                    out_free;
	logic                    can_push;
	logic                    scan_adv;
	logic                    pad_adv;
	logic                    take;
	logic [4:0]              low;
	logic                    push;
	hidkev_pkg::event_kind_t push_kind;
	logic [7:0]              push_code;
	logic                    flush;
	logic                    port_ok;
	logic [13:0]             pad_prev_sel;
	logic [4:0]              pad_now_sel;
	logic [4:0]              pad_prev5;
	logic [31:0]             fresh;

	assign accept   = report_valid && !report_stall;
	assign out_free = !out_valid_q || !event_stall;
	assign can_push = !pend_valid_q || out_free;
	assign scan_adv = !s1_valid_q || can_push;
	assign pad_adv  = !pad_diff_q[pad_step_q] || can_push;
	assign take     = (state_q == hidkev_pkg::ST_KB_SCAN) && scan_adv && (diff_q != 32'd0);
	assign low      = hidkev_pkg::lowest_bit(diff_q);
	assign fresh    = hidkev_pkg::fresh_page(report_q, page_q);

	// gamepad port lookup and watched bits
	always_comb begin
		pad_prev_sel = '0;
		port_ok      = 1'b0;
		for (int i = 0; i < hidkev_pkg::HID_PORTS; i++) begin
			if (int'(port) == i) begin
				pad_prev_sel = pad_prev_q[i];
				port_ok      = 1'b1;
			end
		end
		for (int k = 0; k < hidkev_pkg::PAD_KEYS; k++) begin
			pad_now_sel[k] = pad_buttons[hidkev_pkg::PAD_BITS[k]];
			pad_prev5[k]   = pad_prev_sel[hidkev_pkg::PAD_BITS[k]];
		end
	end

	// translation memory access: map writes at accept, reads while scanning
	always_comb begin
		xlat_req       = '0;
		xlat_req.we    = accept && (operation == hidkev_pkg::OP_MAP_WRITE)
			&& (int'(map_index) < hidkev_pkg::MAP_SLOTS);
		xlat_req.waddr = map_index[SLOT_W-1:0];
		xlat_req.wdata = map_value;
		xlat_req.re    = take;
		xlat_req.raddr = SLOT_W'({page_q, low});
	end

	hidkev_xlat_ram u_xlat (
		.clk     (clk),
		.req     (xlat_req),
		.rd_data (xlat_rd)
	);

	hidkev_page_ram u_page (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (page_req),
		.rd_data (page_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hidkev_pkg::ST_IDLE: begin
				if (accept && operation == hidkev_pkg::OP_REPORT) begin
					if (report_kind == hidkev_pkg::RPT_KEYBOARD) begin
						state_d = hidkev_pkg::ST_KB_READ;
					end else if (report_kind == hidkev_pkg::RPT_MOUSE) begin
						state_d = hidkev_pkg::ST_MOUSE_X;
					end else if (report_kind == hidkev_pkg::RPT_GAMEPAD
							&& !passthru_q && port_ok) begin
						state_d = hidkev_pkg::ST_PAD;
					end
				end
			end
			hidkev_pkg::ST_KB_READ: state_d = hidkev_pkg::ST_KB_DIFF;
			hidkev_pkg::ST_KB_DIFF: state_d = hidkev_pkg::ST_KB_SCAN;
			hidkev_pkg::ST_KB_SCAN: begin
				if (scan_adv && diff_q == 32'd0) begin
					if (page_q == PAGE_W'(hidkev_pkg::MAP_PAGES - 1)) begin
						state_d = hidkev_pkg::ST_FINISH;
					end else begin
						state_d = hidkev_pkg::ST_KB_READ;
					end
				end
			end
			hidkev_pkg::ST_MOUSE_X: begin
				if (can_push) begin
					state_d = hidkev_pkg::ST_MOUSE_Y;
				end
			end
			hidkev_pkg::ST_MOUSE_Y: begin
				if (can_push) begin
					state_d = hidkev_pkg::ST_FINISH;
				end
			end
			hidkev_pkg::ST_PAD: begin
				if (pad_adv && pad_step_q == 3'(hidkev_pkg::PAD_KEYS - 1)) begin
					state_d = hidkev_pkg::ST_FINISH;
				end
			end
			hidkev_pkg::ST_FINISH: begin
				if (!pend_valid_q || out_free) begin
					state_d = hidkev_pkg::ST_IDLE;
				end
			end
			default: state_d = hidkev_pkg::ST_IDLE;
		endcase
	end

	// per-state outputs
	always_comb begin
		page_req  = '0;
		push      = 1'b0;
		push_kind = hidkev_pkg::EV_KEY;
		push_code = 8'd0;
		flush     = 1'b0;
		unique case (state_q)
			hidkev_pkg::ST_IDLE: begin
				push = 1'b0;
			end
			hidkev_pkg::ST_KB_READ: begin
				page_req.re   = 1'b1;
				page_req.addr = page_q;
			end
			hidkev_pkg::ST_KB_DIFF: begin
				page_req.we    = 1'b1;
				page_req.addr  = page_q;
				page_req.wdata = fresh;
			end
			hidkev_pkg::ST_KB_SCAN: begin
				push      = s1_valid_q && scan_adv;
				push_kind = hidkev_pkg::EV_KEY;
				push_code = {rel_s1, xlat_rd};
			end
			hidkev_pkg::ST_MOUSE_X: begin
				push      = can_push;
				push_kind = hidkev_pkg::EV_MOUSE_X;
				push_code = report_q[55:48];
			end
			hidkev_pkg::ST_MOUSE_Y: begin
				push      = can_push;
				push_kind = hidkev_pkg::EV_MOUSE_Y;
				push_code = report_q[47:40];
			end
			hidkev_pkg::ST_PAD: begin
				push      = pad_diff_q[pad_step_q] && can_push;
				push_kind = hidkev_pkg::EV_KEY;
				push_code = {!pad_now_q[pad_step_q], pad_code_q[pad_step_q]};
			end
			hidkev_pkg::ST_FINISH: begin
				flush = pend_valid_q && out_free;
			end
			default: begin
				flush = 1'b0;
			end
		endcase
	end

	// control state, report state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= hidkev_pkg::ST_IDLE;
			passthru_q     <= 1'b0;
			combo_q        <= 8'd69;
			pad_code_q[0]  <= 7'd64;
			pad_code_q[1]  <= 7'd100;
			pad_code_q[2]  <= 7'd56;
			pad_code_q[3]  <= 7'd57;
			pad_code_q[4]  <= 7'd69;
			mouse_button_q <= 8'd0;
			for (int i = 0; i < hidkev_pkg::HID_PORTS; i++) begin
				pad_prev_q[i] <= 14'd0;
			end
			page_q         <= '0;
			pad_step_q     <= 3'd0;
			s1_valid_q     <= 1'b0;
			pend_valid_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			// configuration writes
			if (cfg_valid && cfg_ready) begin
				unique case (hidkev_pkg::cfg_index_t'(cfg_index))
					hidkev_pkg::CFG_PASSTHRU:    passthru_q    <= cfg_data[0];
					hidkev_pkg::CFG_RESET_COMBO: combo_q       <= cfg_data;
					hidkev_pkg::CFG_PAD_BIT6:    pad_code_q[0] <= cfg_data[6:0];
					hidkev_pkg::CFG_PAD_BIT7:    pad_code_q[1] <= cfg_data[6:0];
					hidkev_pkg::CFG_PAD_BIT13:   pad_code_q[2] <= cfg_data[6:0];
					hidkev_pkg::CFG_PAD_BIT11:   pad_code_q[3] <= cfg_data[6:0];
					hidkev_pkg::CFG_PAD_BIT9:    pad_code_q[4] <= cfg_data[6:0];
					default:                     passthru_q    <= passthru_q;
				endcase
			end

			// item start
			if (accept && operation == hidkev_pkg::OP_REPORT) begin
				page_q     <= '0;
				pad_step_q <= 3'd0;
				if (report_kind == hidkev_pkg::RPT_KEYBOARD) begin
					pend_valid_q <= (report_bytes[63:56] == combo_q);
				end
				if (report_kind == hidkev_pkg::RPT_MOUSE) begin
					mouse_button_q <= report_bytes[63:56];
				end
				if (report_kind == hidkev_pkg::RPT_GAMEPAD && !passthru_q) begin
					for (int i = 0; i < hidkev_pkg::HID_PORTS; i++) begin
						if (int'(port) == i) begin
							pad_prev_q[i] <= pad_buttons;
						end
					end
				end
			end

			// page and gamepad step counters
			if (state_q == hidkev_pkg::ST_KB_SCAN && scan_adv && diff_q == 32'd0) begin
				page_q <= page_q + PAGE_W'(1);
			end
			if (state_q == hidkev_pkg::ST_PAD && pad_adv) begin
				pad_step_q <= pad_step_q + 3'd1;
			end

			// translation read stage
			if (state_q == hidkev_pkg::ST_KB_SCAN && scan_adv) begin
				s1_valid_q <= take;
			end

			// pending event: a push moves the older one out, a flush ends the item
			if (push) begin
				pend_valid_q <= 1'b1;
			end else if (flush) begin
				pend_valid_q <= 1'b0;
			end

			// output register
			if ((push && pend_valid_q) || flush) begin
				out_valid_q <= 1'b1;
			end else if (!event_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			report_q   <= report_bytes;
			pad_now_q  <= pad_now_sel;
			pad_diff_q <= pad_now_sel ^ pad_prev5;
			pend_kind_q <= hidkev_pkg::EV_RESET;
			pend_code_q <= 8'd0;
		end

		// compare old and new page
		if (state_q == hidkev_pkg::ST_KB_DIFF) begin
			diff_q  <= page_rd ^ fresh;
			fresh_q <= fresh;
		end else if (take) begin
			diff_q[low] <= 1'b0;
		end
		if (take) begin
			rel_s1 <= !fresh_q[low];
		end

		if (push) begin
			pend_kind_q <= push_kind;
			pend_code_q <= push_code;
		end

		if ((push && pend_valid_q) || flush) begin
			out_kind_q   <= pend_kind_q;
			out_code_q   <= pend_code_q;
			out_button_q <= mouse_button_q;
			out_last_q   <= flush;
		end
	end

	assign report_stall = (state_q != hidkev_pkg::ST_IDLE);
	assign cfg_ready    = 1'b1;
	assign event_valid  = out_valid_q;
	assign event_kind   = out_kind_q;
	assign button_state = out_button_q;
	assign event_code   = out_code_q;
	assign last         = out_last_q;

endmodule
`default_nettype wire
